// ----- hw/rtl/tdfa_pkg.sv -----
package tdfa_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int CMD_W      = 2;
    localparam int CODE_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int STATE_W    = 4;
    localparam int TARGET_W   = 5;
    localparam int STATUS_W   = 2;
    localparam int SYMCNT_W   = 4;
    localparam int STCNT_W    = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_SYMBOL_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STATE_COUNT  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SYMBOL = 2'd0,
        CMD_LOAD_TRANS  = 2'd1,
        CMD_LOAD_FINAL  = 2'd2,
        CMD_WORD_CHAR   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_DEAD     = 2'd3
    } status_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } match_t;

    typedef logic [MAX_STATES-1:0][STATE_W-1:0] trans_row_t;
    typedef logic [MAX_STATES-1:0]              has_row_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] step_count;
        status_t                status;
        logic [STATE_W-1:0]     to_state;
        logic [SLOT_W-1:0]      symbol_slot;
        logic                   from_final;
        logic [STATE_W-1:0]     from_state;
    } result_t;

endpackage

// ----- hw/rtl/tdfa_symbol_match.sv -----
module tdfa_symbol_match import tdfa_pkg::*; (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_slot,
    input  logic [CODE_W-1:0]   wr_code,
    input  logic [SYMCNT_W-1:0] symbol_count,
    input  logic [CODE_W-1:0]   char_code,
    output match_t              match
);

    logic [CODE_W-1:0] codes_reg [MAX_SYMBOLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            codes_reg[wr_slot] <= wr_code;
        end
    end

    // lowest slot in use wins
    always_comb begin
        match = '0;
        for (int s = MAX_SYMBOLS - 1; s >= 0; s--) begin
            if (SYMCNT_W'(s) < symbol_count && codes_reg[s] == char_code) begin
                match.found = 1'b1;
                match.slot  = SLOT_W'(s);
            end
        end
    end

endmodule

// ----- hw/rtl/tdfa_trans_mem.sv -----
module tdfa_trans_mem import tdfa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [SLOT_W-1:0]  wr_slot,
    input  logic [STATE_W-1:0] wr_state,
    input  logic               wr_has,
    input  logic [STATE_W-1:0] wr_target,
    input  logic               rd_en,
    input  logic [SLOT_W-1:0]  rd_slot,
    output trans_row_t         rd_row,
    output has_row_t           rd_has
);

    // one row per symbol slot, one field per source state
    trans_row_t mem [MAX_SYMBOLS];
    has_row_t   has_reg [MAX_SYMBOLS];
    trans_row_t rd_row_reg;
    has_row_t   rd_has_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_slot][wr_state] <= wr_target;
        end
        if (rd_en) begin
            rd_row_reg <= mem[rd_slot];
            rd_has_reg <= has_reg[rd_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < MAX_SYMBOLS; s++) begin
                has_reg[s] <= '0;
            end
        end else if (wr_en) begin
            has_reg[wr_slot][wr_state] <= wr_has;
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_has = rd_has_reg;

endmodule

// ----- hw/rtl/tdfa_step.sv -----
module tdfa_step import tdfa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               char_take,
    input  logic               char_eow,
    input  match_t             char_match,
    input  logic               flag_wr_en,
    input  logic [STATE_W-1:0] flag_wr_state,
    input  logic               flag_wr_value,
    input  logic [STCNT_W-1:0] states_in_use,
    input  trans_row_t         row,
    input  has_row_t           row_has,
    output logic               can_take,
    output logic               m_valid,
    input  logic               m_ready,
    output result_t            m_result
);

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_eow_reg;
    match_t                 s1_match_reg;
    logic [STATE_W-1:0]     cur_state_reg, cur_state_next;
    logic                   dead_reg, dead_next;
    logic [COUNT_WIDTH-1:0] steps_reg, steps_next;
    logic [MAX_STATES-1:0]  acc_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_data_reg, out_data_next;

    logic                   s1_fire;
    logic                   alive;
    logic [STATE_W-1:0]     to_state;
    logic [STATE_W-1:0]     target;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign can_take = !s1_valid_reg || s1_fire;
    assign target   = row[cur_state_reg];

    always_comb begin
        s1_valid_next  = char_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        cur_state_next = cur_state_reg;
        dead_next      = dead_reg;
        steps_next     = steps_reg;
        out_data_next  = out_data_reg;
        to_state       = cur_state_reg;
        alive          = 1'b0;
        if (s1_fire) begin
            if (!dead_reg) begin
                if (!s1_match_reg.found || !row_has[cur_state_reg]
                        || {1'b0, target} >= states_in_use) begin
                    dead_next = 1'b1;
                end else begin
                    to_state       = target;
                    cur_state_next = target;
                    if (steps_reg != {COUNT_WIDTH{1'b1}}) begin
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            alive = !dead_next;
            out_data_next.from_state  = cur_state_reg;
            out_data_next.from_final  = acc_reg[cur_state_reg];
            out_data_next.symbol_slot = (!dead_reg && s1_match_reg.found)
                                        ? s1_match_reg.slot : '0;
            out_data_next.to_state    = to_state;
            out_data_next.step_count  = steps_next;
            if (s1_eow_reg) begin
                out_data_next.status = (alive && acc_reg[to_state]) ? ST_ACCEPTED
                                                                    : ST_REJECTED;
                cur_state_next = '0;
                dead_next      = 1'b0;
                steps_next     = '0;
            end else begin
                out_data_next.status = alive ? ST_RUNNING : ST_DEAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_state_reg <= '0;
            dead_reg      <= 1'b0;
            steps_reg     <= '0;
            acc_reg       <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cur_state_reg <= cur_state_next;
            dead_reg      <= dead_next;
            steps_reg     <= steps_next;
            if (flag_wr_en) begin
                acc_reg[flag_wr_state] <= flag_wr_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (char_take) begin
            s1_eow_reg   <= char_eow;
            s1_match_reg <= char_match;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

endmodule

// ----- hw/rtl/table_driven_dfa_recognizer.sv -----
// Path: a word character's transition row read is registered with its request,
// then the state update is registered into the output register.
// Throughput: one request per cycle unless m_tready stalls the output; the
// state loop reads no table, as rows are addressed by slot, not by state.
// Reset (aresetn low, synchronous): state 0, empty transition table, no final
// states, both counts 1; symbol codes stay undefined until loaded.
module table_driven_dfa_recognizer import tdfa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // char_code[7:0], slot[10:8], state_sel[14:11], target_state[19:15],
    // final_flag[20], zero[23:21]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // from_state[3:0], from_final[4], symbol_slot[7:5], to_state[11:8],
    // status[13:12], step_count[29:14], zero[31:30]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [SYMCNT_W-1:0] symbol_count_reg;
    logic [STCNT_W-1:0]  state_count_reg;
    logic [STCNT_W-1:0]  states_in_use;

    cmd_t                cmd;
    logic                accept;
    logic [CODE_W-1:0]   char_code;
    logic [SLOT_W-1:0]   slot;
    logic [STATE_W-1:0]  state_sel;
    logic [TARGET_W-1:0] target_state;
    logic                final_flag;
    logic                sel_in_use;

    match_t              match;
    trans_row_t          row;
    has_row_t            row_has;
    result_t             result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg <= SYMCNT_W'(1);
            state_count_reg  <= STCNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg_wdata[SYMCNT_W-1:0];
                REG_STATE_COUNT:  state_count_reg  <= cfg_wdata[STCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign states_in_use = (state_count_reg > STCNT_W'(MAX_STATES))
                           ? STCNT_W'(MAX_STATES) : state_count_reg;

    assign cmd          = cmd_t'(s_tuser);
    assign accept       = s_tvalid && s_tready;
    assign char_code    = s_tdata[7:0];
    assign slot         = s_tdata[10:8];
    assign state_sel    = s_tdata[14:11];
    assign target_state = s_tdata[19:15];
    assign final_flag   = s_tdata[20];
    assign sel_in_use   = {1'b0, state_sel} < states_in_use;

    tdfa_symbol_match u_match (
        .aclk         (aclk),
        .wr_en        (accept && cmd == CMD_LOAD_SYMBOL),
        .wr_slot      (slot),
        .wr_code      (char_code),
        .symbol_count (symbol_count_reg),
        .char_code    (char_code),
        .match        (match)
    );

    tdfa_trans_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (accept && cmd == CMD_LOAD_TRANS && sel_in_use),
        .wr_slot   (slot),
        .wr_state  (state_sel),
        .wr_has    (!target_state[TARGET_W-1]),
        .wr_target (target_state[STATE_W-1:0]),
        .rd_en     (accept && cmd == CMD_WORD_CHAR),
        .rd_slot   (match.slot),
        .rd_row    (row),
        .rd_has    (row_has)
    );

    tdfa_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .char_take     (accept && cmd == CMD_WORD_CHAR),
        .char_eow      (s_tlast),
        .char_match    (match),
        .flag_wr_en    (accept && cmd == CMD_LOAD_FINAL && sel_in_use),
        .flag_wr_state (state_sel),
        .flag_wr_value (final_flag),
        .states_in_use (states_in_use),
        .row           (row),
        .row_has       (row_has),
        .can_take      (s_tready),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_result      (result)
    );

    assign m_tdata = {2'b00, result};

endmodule
